// ===== rtl/sem_pkg.sv =====
// shared constants, opcodes and status codes of the stack expression machine
package sem_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int SP_W        = ADDR_W + 1;
   localparam int WORD_W      = 64;
   localparam int HALF_W      = WORD_W / 2;
   localparam int SHAMT_W     = $clog2(WORD_W);
   localparam int PC_W        = 16;
   localparam int MODE_W      = 5;
   localparam int IDX_W       = 8;
   localparam int STAT_W      = 2;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [MODE_W-1:0] {
      OP_LOR   = 5'd0,
      OP_LAND  = 5'd1,
      OP_LE    = 5'd2,
      OP_LT    = 5'd3,
      OP_GE    = 5'd4,
      OP_GT    = 5'd5,
      OP_NE    = 5'd6,
      OP_EQ    = 5'd7,
      OP_BOR   = 5'd8,
      OP_BAND  = 5'd9,
      OP_BXOR  = 5'd10,
      OP_SHL   = 5'd11,
      OP_SHR   = 5'd12,
      OP_ADD   = 5'd13,
      OP_MUL   = 5'd14,
      OP_SUB   = 5'd15,
      OP_DIV   = 5'd16,
      OP_MOD   = 5'd17,
      OP_LNOT  = 5'd18,
      OP_BNOT  = 5'd19,
      OP_NEG   = 5'd20,
      OP_BRZ   = 5'd21,
      OP_JMP   = 5'd22,
      OP_PARAM = 5'd23,
      OP_CALL  = 5'd24,
      OP_RET   = 5'd25,
      OP_NOP   = 5'd26,
      OP_PUSH  = 5'd27
   } op_type;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;
   localparam logic [STAT_W-1:0] ST_DIVZ  = 2'd3;

endpackage

// ===== rtl/sem_req_if.sv =====
// instruction channel of the stack expression machine
interface sem_req_if import sem_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [WORD_W-1:0] immediate;
   logic [PC_W-1:0]   target_pc;
   logic [PC_W-1:0]   fall_through_pc;
   logic [IDX_W-1:0]  param_index;
   logic [IDX_W-1:0]  callee_params;

   modport source (output valid, mode, immediate, target_pc, fall_through_pc,
                   param_index, callee_params, input ready);
   modport sink   (input valid, mode, immediate, target_pc, fall_through_pc,
                   param_index, callee_params, output ready);
endinterface

// ===== rtl/sem_rsp_if.sv =====
// result channel of the stack expression machine
interface sem_rsp_if import sem_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] top_value;
   logic [SP_W-1:0]   depth;
   logic [PC_W-1:0]   next_pc;
   logic [STAT_W-1:0] status;

   modport source (output valid, top_value, depth, next_pc, status, input ready);
   modport sink   (input valid, top_value, depth, next_pc, status, output ready);
endinterface

// ===== rtl/sem_ram.sv =====
// generic single write port ram with registered read
module sem_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/stack_expression_machine.sv =====
// stack expression machine top level: rpn stack machine with call frames
//
// req_ch carries one instruction per beat, rsp_ch returns exactly one result
// beat per instruction (top of stack, depth, next pc, status), in order.
// the stack words live in one ram with a registered read; the top
// word is also kept in a register so most operations need at most one read.
// multiply forms three partial products in one 32x32 multiplier; divide
// and modulo use a restoring divider, one quotient bit per cycle.
// one instruction is in flight at a time; the next is taken once the previous
// result sits in the output register, even while that beat is still stalled.
// a stalled rsp_ch holds the result and blocks only the completion of the
// following instruction. reset (synchronous) empties the stack and clears the
// frame pointer; the ram itself is not cleared and needs no clearing pass.
module stack_expression_machine import sem_pkg::*; (
   input logic     clock,
   input logic     reset,
   sem_req_if.sink   req_ch,
   sem_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_OPER, S_MUL, S_DIV, S_DSGN, S_PARAM, S_CALL2, S_RET1, S_RET2, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [SP_W-1:0]    sp_ff, sp_in, fp_ff, fp_in;
   word_type           tos_ff, tos_in;
   op_type             op_ff, op_in;
   logic [PC_W-1:0]    tgt_ff, tgt_in, npc_ff, npc_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in, cpar_ff, cpar_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   // arithmetic unit registers
   word_type           opa_ff, opa_in, opb_ff, opb_in;
   word_type           quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   word_type           acc_ff, acc_in, prod_ff, prod_in;
   logic [SHAMT_W-1:0] cnt_ff, cnt_in;
   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_top_ff, rsp_top_in;
   logic [SP_W-1:0]    rsp_depth_ff, rsp_depth_in;
   logic [PC_W-1:0]    rsp_npc_ff, rsp_npc_in;
   logic [STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;

   // stack ram port
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   word_type           mem_wdata, mem_rdata;

   logic               accept;
   op_type             req_op;
   logic [SP_W-1:0]    sp_m1, sp_m2, sp_m3, sp_p1;
   logic [SP_W:0]      ret_need, param_addr, ret_base, ret_sp;
   logic [STAT_W-1:0]  chk_status;
   word_type           alu_a, alu_b, alu_res, una_res, mul_fin, div_res;
   word_type           mag_a, mag_b, rem_sh;
   logic               shift_ok, rem_ge;
   logic [HALF_W-1:0]  mul_x, mul_y;

   sem_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign accept           = req_ch.valid && req_ch.ready;
   assign req_op           = op_type'(req_ch.mode);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.top_value = rsp_top_ff;
   assign rsp_ch.depth     = rsp_depth_ff;
   assign rsp_ch.next_pc   = rsp_npc_ff;
   assign rsp_ch.status    = rsp_stat_ff;

   assign sp_m1 = sp_ff - SP_W'(1);
   assign sp_m2 = sp_ff - SP_W'(2);
   assign sp_m3 = sp_ff - SP_W'(3);
   assign sp_p1 = sp_ff + SP_W'(1);
   assign ret_need   = (SP_W+1)'(req_ch.param_index) + (SP_W+1)'(3);
   assign param_addr = (SP_W+1)'(fp_ff) + (SP_W+1)'(pidx_ff);
   assign ret_base   = (SP_W+1)'(sp_ff) - (SP_W+1)'(pidx_ff) - (SP_W+1)'(3);
   assign ret_sp     = (SP_W+1)'(sp_ff) - (SP_W+1)'(pidx_ff) - (SP_W+1)'(2);

   // stack bounds check of the incoming instruction
   always_comb begin
      chk_status = ST_OK;
      if (req_ch.mode <= MODE_W'(OP_MOD)) begin
         if (sp_ff < SP_W'(2)) chk_status = ST_UNDER;
      end else if (req_ch.mode <= MODE_W'(OP_BRZ)) begin
         if (sp_ff == '0) chk_status = ST_UNDER;
      end else begin
         case (req_op)
            OP_PARAM, OP_PUSH: begin
               if (sp_ff >= SP_W'(STACK_DEPTH)) chk_status = ST_OVER;
            end
            OP_CALL: begin
               if (sp_ff > SP_W'(STACK_DEPTH - 2)) chk_status = ST_OVER;
               else if (SP_W'(req_ch.callee_params) > sp_ff) chk_status = ST_UNDER;
            end
            OP_RET: begin
               if ((SP_W+1)'(sp_ff) < ret_need) chk_status = ST_UNDER;
            end
            default: chk_status = ST_OK;
         endcase
      end
   end

   // combinational binary and unary operations; a is second from top
   assign alu_a    = mem_rdata;
   assign alu_b    = tos_ff;
   assign shift_ok = (alu_b[WORD_W-1:SHAMT_W] == '0);

   always_comb begin
      case (op_ff)
         OP_LOR:  alu_res = WORD_W'((alu_a != '0) || (alu_b != '0));
         OP_LAND: alu_res = WORD_W'((alu_a != '0) && (alu_b != '0));
         OP_LE:   alu_res = WORD_W'($signed(alu_a) <= $signed(alu_b));
         OP_LT:   alu_res = WORD_W'($signed(alu_a) <  $signed(alu_b));
         OP_GE:   alu_res = WORD_W'($signed(alu_a) >= $signed(alu_b));
         OP_GT:   alu_res = WORD_W'($signed(alu_a) >  $signed(alu_b));
         OP_NE:   alu_res = WORD_W'(alu_a != alu_b);
         OP_EQ:   alu_res = WORD_W'(alu_a == alu_b);
         OP_BOR:  alu_res = alu_a | alu_b;
         OP_BAND: alu_res = alu_a & alu_b;
         OP_BXOR: alu_res = alu_a ^ alu_b;
         OP_SHL:  alu_res = shift_ok ? (alu_a << alu_b[SHAMT_W-1:0]) : '0;
         OP_SHR:  alu_res = shift_ok ? WORD_W'($signed(alu_a) >>> alu_b[SHAMT_W-1:0])
                                     : {WORD_W{alu_a[WORD_W-1]}};
         OP_ADD:  alu_res = alu_a + alu_b;
         OP_SUB:  alu_res = alu_a - alu_b;
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_LNOT: una_res = WORD_W'(tos_ff == '0);
         OP_BNOT: una_res = ~tos_ff;
         default: una_res = '0 - tos_ff;
      endcase
   end

   assign mag_a = alu_a[WORD_W-1] ? ('0 - alu_a) : alu_a;
   assign mag_b = alu_b[WORD_W-1] ? ('0 - alu_b) : alu_b;

   // multiplier: low word from three half-width partial products
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    begin mul_x = opa_ff[HALF_W-1:0];      mul_y = opb_ff[HALF_W-1:0];      end
         2'd1:    begin mul_x = opa_ff[HALF_W-1:0];      mul_y = opb_ff[WORD_W-1:HALF_W]; end
         default: begin mul_x = opa_ff[WORD_W-1:HALF_W]; mul_y = opb_ff[HALF_W-1:0];      end
      endcase
   end
   assign mul_fin = acc_ff + {prod_ff[HALF_W-1:0], HALF_W'(0)};

   // restoring divider step; remainder stays below the divisor
   assign rem_sh = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
   assign rem_ge = (rem_sh >= dvs_ff);
   always_comb begin
      if (op_ff == OP_DIV) begin
         div_res = (opa_ff[WORD_W-1] ^ opb_ff[WORD_W-1]) ? ('0 - quo_ff) : quo_ff;
      end else begin
         div_res = opa_ff[WORD_W-1] ? ('0 - rem_ff) : rem_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      fp_in     = fp_ff;
      tos_in    = tos_ff;
      op_in     = op_ff;
      tgt_in    = tgt_ff;
      npc_in    = npc_ff;
      pidx_in   = pidx_ff;
      cpar_in   = cpar_ff;
      status_in = status_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      mem_we    = 1'b0;
      mem_waddr = sp_m2[ADDR_W-1:0];
      mem_wdata = alu_res;
      mem_raddr = sp_m2[ADDR_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_top_in   = rsp_top_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_npc_in   = rsp_npc_ff;
      rsp_stat_in  = rsp_stat_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               tgt_in    = req_ch.target_pc;
               pidx_in   = req_ch.param_index;
               cpar_in   = req_ch.callee_params;
               npc_in    = req_ch.fall_through_pc;
               status_in = chk_status;
               state_in  = S_DONE;
               if (chk_status == ST_OK) begin
                  if (req_ch.mode <= MODE_W'(OP_BRZ)) begin
                     // binary, unary and branch: fetch second from top
                     state_in = S_OPER;
                     if (req_op == OP_BRZ && tos_ff == '0) npc_in = req_ch.target_pc;
                  end else begin
                     case (req_op)
                        OP_JMP: npc_in = req_ch.target_pc;
                        OP_PARAM: begin
                           mem_raddr = ADDR_W'(fp_ff + SP_W'(req_ch.param_index));
                           state_in  = S_PARAM;
                        end
                        OP_CALL: begin
                           // link word: return address
                           mem_we    = 1'b1;
                           mem_waddr = sp_ff[ADDR_W-1:0];
                           mem_wdata = WORD_W'(req_ch.fall_through_pc);
                           state_in  = S_CALL2;
                        end
                        OP_RET: begin
                           mem_raddr = sp_m3[ADDR_W-1:0];
                           state_in  = S_RET1;
                        end
                        OP_PUSH: begin
                           mem_we    = 1'b1;
                           mem_waddr = sp_ff[ADDR_W-1:0];
                           mem_wdata = req_ch.immediate;
                           tos_in    = req_ch.immediate;
                           sp_in     = sp_p1;
                        end
                        default: state_in = S_DONE;
                     endcase
                  end
               end
            end
         end
         S_OPER: begin
            state_in = S_DONE;
            if (op_ff == OP_BRZ) begin
               tos_in = mem_rdata;
               sp_in  = sp_m1;
            end else if (op_ff == OP_LNOT || op_ff == OP_BNOT || op_ff == OP_NEG) begin
               mem_we    = 1'b1;
               mem_waddr = sp_m1[ADDR_W-1:0];
               mem_wdata = una_res;
               tos_in    = una_res;
            end else if (op_ff == OP_MUL) begin
               opa_in   = alu_a;
               opb_in   = alu_b;
               cnt_in   = '0;
               state_in = S_MUL;
            end else if ((op_ff == OP_DIV || op_ff == OP_MOD) && alu_b != '0) begin
               opa_in   = alu_a;
               opb_in   = alu_b;
               quo_in   = mag_a;
               dvs_in   = mag_b;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               // simple binary op, or divide by zero which pushes zero
               if (op_ff == OP_DIV || op_ff == OP_MOD) begin
                  status_in = ST_DIVZ;
                  mem_wdata = '0;
               end
               mem_we    = 1'b1;
               mem_waddr = sp_m2[ADDR_W-1:0];
               tos_in    = mem_wdata;
               sp_in     = sp_m1;
            end
         end
         S_MUL: begin
            prod_in = mul_x * mul_y;
            cnt_in  = cnt_ff + SHAMT_W'(1);
            case (cnt_ff[1:0])
               2'd0:    acc_in = acc_ff;
               2'd1:    acc_in = prod_ff;
               default: acc_in = mul_fin;
            endcase
            if (cnt_ff[1:0] == 2'd3) begin
               mem_we    = 1'b1;
               mem_waddr = sp_m2[ADDR_W-1:0];
               mem_wdata = mul_fin;
               tos_in    = mul_fin;
               sp_in     = sp_m1;
               state_in  = S_DONE;
            end
         end
         S_DIV: begin
            rem_in = rem_ge ? (rem_sh - dvs_ff) : rem_sh;
            quo_in = {quo_ff[WORD_W-2:0], rem_ge};
            cnt_in = cnt_ff + SHAMT_W'(1);
            if (cnt_ff == SHAMT_W'(WORD_W - 1)) state_in = S_DSGN;
         end
         S_DSGN: begin
            mem_we    = 1'b1;
            mem_waddr = sp_m2[ADDR_W-1:0];
            mem_wdata = div_res;
            tos_in    = div_res;
            sp_in     = sp_m1;
            state_in  = S_DONE;
         end
         S_PARAM: begin
            mem_we    = 1'b1;
            mem_waddr = sp_ff[ADDR_W-1:0];
            mem_wdata = (param_addr < (SP_W+1)'(STACK_DEPTH)) ? mem_rdata : '0;
            tos_in    = mem_wdata;
            sp_in     = sp_p1;
            state_in  = S_DONE;
         end
         S_CALL2: begin
            // link word: caller frame pointer
            mem_we    = 1'b1;
            mem_waddr = sp_p1[ADDR_W-1:0];
            mem_wdata = WORD_W'(fp_ff);
            tos_in    = WORD_W'(fp_ff);
            sp_in     = sp_ff + SP_W'(2);
            fp_in     = sp_ff - SP_W'(cpar_ff);
            npc_in    = tgt_ff;
            state_in  = S_DONE;
         end
         S_RET1: begin
            npc_in    = mem_rdata[PC_W-1:0];
            mem_raddr = sp_m2[ADDR_W-1:0];
            state_in  = S_RET2;
         end
         S_RET2: begin
            // saved frame pointer saturates to the stack depth
            if (mem_rdata[WORD_W-1] || mem_rdata > WORD_W'(STACK_DEPTH)) begin
               fp_in = SP_W'(STACK_DEPTH);
            end else begin
               fp_in = mem_rdata[SP_W-1:0];
            end
            mem_we    = 1'b1;
            mem_waddr = ret_base[ADDR_W-1:0];
            mem_wdata = tos_ff;
            sp_in     = ret_sp[SP_W-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_top_in   = (sp_ff == '0) ? '0 : tos_ff;
               rsp_depth_in = sp_ff;
               rsp_npc_in   = npc_ff;
               rsp_stat_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         fp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         fp_ff        <= fp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tos_ff       <= tos_in;
      op_ff        <= op_in;
      tgt_ff       <= tgt_in;
      npc_ff       <= npc_in;
      pidx_ff      <= pidx_in;
      cpar_ff      <= cpar_in;
      status_ff    <= status_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      cnt_ff       <= cnt_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_npc_ff   <= rsp_npc_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted beat did not start execution");

   a_fp_only_call_ret: assert property (@(posedge clock) disable iff (reset)
      (fp_ff != $past(fp_ff)) |-> ($past(state_ff) == S_CALL2 || $past(state_ff) == S_RET2))
      else $error("frame pointer changed outside call or return");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result beat raised outside completion");

endmodule

// ===== tb/sv/stack_expression_machine_tb.sv =====
// self-checking testbench of the stack expression machine
module stack_expression_machine_tb import sem_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // highest encodable opcode; everything above OP_PUSH decodes as a nop
   localparam logic [MODE_W-1:0] MODE_TOP = '1;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 420;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      word_type          immediate;
      logic [PC_W-1:0]   target_pc;
      logic [PC_W-1:0]   fall_pc;
      logic [IDX_W-1:0]  param_index;
      logic [IDX_W-1:0]  callee_params;
   } instr_beat_type;

   typedef struct packed {
      word_type          top_value;
      logic [SP_W-1:0]   depth;
      logic [PC_W-1:0]   next_pc;
      logic [STAT_W-1:0] status;
   } step_outcome_type;

   logic clock;
   logic reset;

   sem_req_if req_ch ();
   sem_rsp_if rsp_ch ();

   stack_expression_machine u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the machine: stack words, which words hold data, sp and fp
   word_type    stack_words [STACK_DEPTH];
   bit          word_written[STACK_DEPTH];
   int unsigned stack_depth;
   int unsigned frame_ptr;

   step_outcome_type expected_steps[$];
   int mismatches;
   int items_sent;
   int cycle_count;
   int hold_left;
   int ready_gap;
   bit steady_traffic;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic void store_word(int unsigned idx, word_type value);
      stack_words[idx]  = value;
      word_written[idx] = 1'b1;
   endfunction

   // magnitude of a two's complement word, the most negative stays as is
   function automatic word_type magnitude(word_type x);
      return x[WORD_W-1] ? word_type'(0) - x : x;
   endfunction

   // left operand is second from top, right operand is the top word
   function automatic word_type binary_result(logic [MODE_W-1:0] mode, word_type lhs,
                                              word_type rhs, inout logic [STAT_W-1:0] st);
      word_type q;
      bit       count_ok;
      count_ok = !rhs[WORD_W-1] && rhs < WORD_W;
      case (mode)
         OP_LOR:  return word_type'(lhs != 0 || rhs != 0);
         OP_LAND: return word_type'(lhs != 0 && rhs != 0);
         OP_LE:   return word_type'($signed(lhs) <= $signed(rhs));
         OP_LT:   return word_type'($signed(lhs) <  $signed(rhs));
         OP_GE:   return word_type'($signed(lhs) >= $signed(rhs));
         OP_GT:   return word_type'($signed(lhs) >  $signed(rhs));
         OP_NE:   return word_type'(lhs != rhs);
         OP_EQ:   return word_type'(lhs == rhs);
         OP_BOR:  return lhs | rhs;
         OP_BAND: return lhs & rhs;
         OP_BXOR: return lhs ^ rhs;
         // counts outside 0..63 flush to zero or to sign fill
         OP_SHL:  return count_ok ? lhs << rhs[SHAMT_W-1:0] : word_type'(0);
         OP_SHR:  return count_ok ? word_type'($signed(lhs) >>> rhs[SHAMT_W-1:0])
                                  : {WORD_W{lhs[WORD_W-1]}};
         OP_ADD:  return lhs + rhs;
         OP_MUL:  return lhs * rhs;
         OP_SUB:  return lhs - rhs;
         OP_DIV: begin
            if (rhs == 0) begin
               st = ST_DIVZ;
               return '0;
            end
            q = magnitude(lhs) / magnitude(rhs);
            return (lhs[WORD_W-1] ^ rhs[WORD_W-1]) ? word_type'(0) - q : q;
         end
         default: begin
            if (rhs == 0) begin
               st = ST_DIVZ;
               return '0;
            end
            q = magnitude(lhs) % magnitude(rhs);
            return lhs[WORD_W-1] ? word_type'(0) - q : q;
         end
      endcase
   endfunction

   // executes one instruction on the shadow state and returns its result beat
   function automatic step_outcome_type execute_instr(instr_beat_type ib);
      step_outcome_type o;
      int unsigned   sp;
      int unsigned   addr;
      int unsigned   pidx;
      word_type      w;
      sp        = stack_depth;
      pidx      = ib.param_index;
      o.status  = ST_OK;
      o.next_pc = ib.fall_pc;
      if (ib.mode <= OP_MOD) begin
         if (sp < 2) o.status = ST_UNDER;
         else begin
            store_word(sp - 2, binary_result(ib.mode, stack_words[sp-2], stack_words[sp-1],
                                             o.status));
            stack_depth = sp - 1;
         end
      end else if (ib.mode <= OP_NEG) begin
         if (sp < 1) o.status = ST_UNDER;
         else begin
            w = stack_words[sp-1];
            case (ib.mode)
               OP_LNOT: w = word_type'(w == 0);
               OP_BNOT: w = ~w;
               default: w = word_type'(0) - w;
            endcase
            store_word(sp - 1, w);
         end
      end else if (ib.mode == OP_BRZ) begin
         if (sp < 1) o.status = ST_UNDER;
         else begin
            if (stack_words[sp-1] == 0) o.next_pc = ib.target_pc;
            stack_depth = sp - 1;
         end
      end else if (ib.mode == OP_JMP) begin
         o.next_pc = ib.target_pc;
      end else if (ib.mode == OP_PARAM) begin
         if (sp >= STACK_DEPTH) o.status = ST_OVER;
         else begin
            addr = frame_ptr + pidx;
            store_word(sp, (addr < STACK_DEPTH) ? stack_words[addr] : word_type'(0));
            stack_depth = sp + 1;
         end
      end else if (ib.mode == OP_CALL) begin
         if (sp + 2 > STACK_DEPTH) o.status = ST_OVER;
         else if (ib.callee_params > sp) o.status = ST_UNDER;
         else begin
            // link words: return address, then the caller's frame pointer
            store_word(sp, word_type'(ib.fall_pc));
            store_word(sp + 1, word_type'(frame_ptr));
            stack_depth = sp + 2;
            frame_ptr   = sp - ib.callee_params;
            o.next_pc   = ib.target_pc;
         end
      end else if (ib.mode == OP_RET) begin
         if (sp < 3 + pidx) o.status = ST_UNDER;
         else begin
            o.next_pc = stack_words[sp-3][PC_W-1:0];
            w         = stack_words[sp-2];
            // a bogus saved frame word saturates to the stack size
            frame_ptr = (w[WORD_W-1] || w > STACK_DEPTH) ? STACK_DEPTH : int'(w);
            store_word(sp - (3 + pidx), stack_words[sp-1]);
            stack_depth = sp - (2 + pidx);
         end
      end else if (ib.mode == OP_PUSH) begin
         if (sp >= STACK_DEPTH) o.status = ST_OVER;
         else begin
            store_word(sp, ib.immediate);
            stack_depth = sp + 1;
         end
      end
      o.top_value = (stack_depth > 0) ? stack_words[stack_depth-1] : word_type'(0);
      o.depth     = stack_depth[SP_W-1:0];
      return o;
   endfunction

   // a param may land on a word that was never written; that read is never caused
   function automatic bit param_readable(logic [IDX_W-1:0] pidx);
      int unsigned addr;
      addr = frame_ptr + pidx;
      return addr >= STACK_DEPTH || word_written[addr];
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic int pick_gap(int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // operand values lean toward the corners and toward shift counts
   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return word_type'(1);
         2:       return '1;
         3:       return {1'b1, {(WORD_W-1){1'b0}}};
         4:       return {1'b0, {(WORD_W-1){1'b1}}};
         5:       return word_type'($urandom_range(0, 140)) - word_type'(70);
         6:       return word_type'($urandom_range(0, WORD_W - 1));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic instr_beat_type make_instr(logic [MODE_W-1:0] mode, word_type imm,
                                                 logic [IDX_W-1:0] pidx,
                                                 logic [IDX_W-1:0] cpar);
      instr_beat_type ib;
      ib.mode          = mode;
      ib.immediate     = imm;
      ib.target_pc     = PC_W'($urandom_range(0, 16'hffff));
      ib.fall_pc       = PC_W'($urandom_range(0, 16'hffff));
      ib.param_index   = pidx;
      ib.callee_params = cpar;
      return ib;
   endfunction

   // drives one beat, waits for the handshake and records its expected result;
   // valid stays high when the next beat follows right away
   task automatic send_item(input instr_beat_type ib);
      int gap;
      if (ib.mode == OP_PARAM && !param_readable(ib.param_index)) ib.mode = OP_NOP;
      req_ch.valid           <= 1'b1;
      req_ch.mode            <= ib.mode;
      req_ch.immediate       <= ib.immediate;
      req_ch.target_pc       <= ib.target_pc;
      req_ch.fall_through_pc <= ib.fall_pc;
      req_ch.param_index     <= ib.param_index;
      req_ch.callee_params   <= ib.callee_params;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_steps.push_back(execute_instr(ib));
      items_sent++;
      gap = steady_traffic ? 0 : pick_gap(60);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push_word(input word_type v);
      send_item(make_instr(OP_PUSH, v, '0, '0));
   endtask

   task automatic run_op(input logic [MODE_W-1:0] mode);
      send_item(make_instr(mode, rand_word(), '0, '0));
   endtask

   // sender goes quiet until every expected result has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_steps.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // empty-stack underflows, corner arithmetic, unary ops, branches, spare opcodes
   task automatic test_opcode_corners();
      instr_beat_type ib;
      run_op(OP_ADD);
      run_op(OP_BRZ);
      send_item(make_instr(OP_RET, '0, '0, '0));
      send_item(make_instr(OP_CALL, '0, '0, 8'd1));
      // most negative divided by minus one wraps
      push_word({1'b1, {(WORD_W-1){1'b0}}});
      push_word('1);
      run_op(OP_DIV);
      // modulo by zero
      push_word(word_type'(5));
      push_word('0);
      run_op(OP_MOD);
      // right shift past the word fills with the sign
      push_word(word_type'(-8));
      push_word(word_type'(WORD_W + 6));
      run_op(OP_SHR);
      // negative left shift count
      push_word(word_type'(3));
      push_word('1);
      run_op(OP_SHL);
      run_op(OP_LNOT);
      run_op(OP_BNOT);
      run_op(OP_NEG);
      // top is nonzero here: fall through, then zero takes the branch
      run_op(OP_BRZ);
      push_word('0);
      run_op(OP_BRZ);
      ib = make_instr(OP_JMP, {1'b0, {(WORD_W-1){1'b1}}}, '1, '1);
      ib.target_pc = '1;
      ib.fall_pc   = '1;
      send_item(ib);
      run_op(OP_NOP);
      send_item(make_instr(MODE_TOP, rand_word(), '1, '1));
   endtask

   // a call frame, a return with a bogus saved frame and a truncated return address
   task automatic test_call_frames();
      push_word(word_type'(11));
      push_word(word_type'(22));
      send_item(make_instr(OP_CALL, '0, '0, 8'd2));
      send_item(make_instr(OP_PARAM, '0, 8'd0, '0));
      send_item(make_instr(OP_PARAM, '0, 8'd1, '0));
      run_op(OP_ADD);
      send_item(make_instr(OP_RET, '0, 8'd2, '0));
      push_word(word_type'(64'h0000_0001_0000_abcd));
      push_word(word_type'(-5));
      push_word(word_type'(9));
      send_item(make_instr(OP_RET, '0, '0, '0));
      // frame pointer now sits at the stack size, so the read falls outside
      send_item(make_instr(OP_PARAM, '0, 8'd0, '0));
   endtask

   // fill to the last entry, bounce off it, then unwind with one wide return
   task automatic test_stack_limits();
      while (stack_depth < STACK_DEPTH) push_word(rand_word());
      push_word(rand_word());
      send_item(make_instr(OP_PARAM, '0, 8'd0, '0));
      send_item(make_instr(OP_CALL, '0, '0, '0));
      run_op(OP_ADD);
      send_item(make_instr(OP_CALL, '0, '0, '0));
      push_word(rand_word());
      send_item(make_instr(OP_RET, '0, IDX_W'(STACK_DEPTH - 3), '0));
   endtask

   // receiver holds off while the sender keeps offering, then the sender pauses
   task automatic test_backpressure();
      wait_drained();
      hold_left      = 300;
      steady_traffic = 1'b1;
      repeat (6) push_word(rand_word());
      repeat (5) run_op(MODE_W'($urandom_range(OP_LOR, OP_MOD)));
      run_op(OP_MUL);
      steady_traffic = 1'b0;
      wait_drained();
   endtask

   // one well-formed call: args, call, a body that leaves one value, return
   task automatic run_frame(input int level);
      int n;
      int k;
      n = $urandom_range(0, 4);
      k = $urandom_range(1, 4);
      repeat (n) push_word(rand_word());
      send_item(make_instr(OP_CALL, '0, '0, IDX_W'(n)));
      for (int j = 0; j < k; j++) begin
         if (level < 2 && $urandom_range(0, 7) == 0) run_frame(level + 1);
         else if (n > 0 && $urandom_range(0, 1) == 1)
            send_item(make_instr(OP_PARAM, '0, IDX_W'($urandom_range(0, n - 1)), '0));
         else push_word(rand_word());
         if ($urandom_range(0, 5) == 0) run_op(MODE_W'($urandom_range(OP_LNOT, OP_NEG)));
      end
      repeat (k - 1) run_op(MODE_W'($urandom_range(OP_LOR, OP_MOD)));
      send_item(make_instr(OP_RET, '0, IDX_W'(n), '0));
   endtask

   // raw item with every field random; a fair share hits error paths
   task automatic run_noise_item();
      instr_beat_type ib;
      ib = make_instr(MODE_W'($urandom_range(0, MODE_TOP)), {$urandom, $urandom},
                      $urandom_range(0, 3) == 0 ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 3)),
                      $urandom_range(0, 3) == 0 ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 3)));
      send_item(ib);
   endtask

   task automatic test_random_programs();
      int stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         steady_traffic = ($urandom_range(0, 6) == 0);
         if (stack_depth > 230) run_op(MODE_W'($urandom_range(OP_LOR, OP_MOD)));
         else if ($urandom_range(0, 3) != 0) run_frame(0);
         else run_noise_item();
      end
      steady_traffic = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_beat
      step_outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_steps.size() == 0) report_mismatch("unexpected beat", rsp_ch.top_value, '0);
         else begin
            want = expected_steps.pop_front();
            if (rsp_ch.top_value !== want.top_value)
               report_mismatch("top_value", rsp_ch.top_value, want.top_value);
            if (rsp_ch.depth !== want.depth)
               report_mismatch("depth", word_type'(rsp_ch.depth), word_type'(want.depth));
            if (rsp_ch.next_pc !== want.next_pc)
               report_mismatch("next_pc", word_type'(rsp_ch.next_pc), word_type'(want.next_pc));
            if (rsp_ch.status !== want.status)
               report_mismatch("status", word_type'(rsp_ch.status), word_type'(want.status));
         end
      end
   end

   // result side: random stalls, plus a long hold-off counted down here
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (ready_gap != 0) begin
         rsp_ch.ready <= 1'b0;
         ready_gap--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!steady_traffic) ready_gap = pick_gap(75);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.mode            = '0;
      req_ch.immediate       = '0;
      req_ch.target_pc       = '0;
      req_ch.fall_through_pc = '0;
      req_ch.param_index     = '0;
      req_ch.callee_params   = '0;
      rsp_ch.ready           = 1'b0;
      stack_depth            = 0;
      frame_ptr              = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_opcode_corners();
      test_call_frames();
      test_stack_limits();
      test_backpressure();
      test_random_programs();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sem_pkg.sv
rtl/sem_req_if.sv
rtl/sem_rsp_if.sv
rtl/sem_ram.sv
rtl/stack_expression_machine.sv
tb/sv/stack_expression_machine_tb.sv
